// ===== sv/lfgd_pkg.sv =====
// Shared types, constants and command codes of the linear fit trainer.
`default_nettype none
package lfgd_pkg;

    // Store size and derived widths
    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Arithmetic widths
    localparam int SUM_W  = 58;  // signed gradient sums
    localparam int MAG_W  = 57;  // magnitude of a sum, cost sum, quotient
    localparam int DIVR_W = CNT_W + 1;  // divisor holds 2m
    localparam int LR_W   = 24;
    localparam int IT_W   = 16;
    localparam int CFG_W  = 24;
    localparam int CFG_A_W = 2;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_LEARN_RATE = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_ITER_COUNT = 2'd1;

    // Divider operand selection
    localparam logic [1:0] SRC_S0   = 2'd0;
    localparam logic [1:0] SRC_S1   = 2'd1;
    localparam logic [1:0] SRC_COST = 2'd2;

    typedef struct packed {
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic               last_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] intercept;
        logic signed [31:0] slope;
        logic [47:0]        final_cost;
        logic [10:0]        samples_used;
        logic               overflow_flag;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_issue;
        logic [ADDR_W-1:0] rd_addr;
        logic              cost_mode;
        logic              clear_thetas;
        logic              clear_sums;
        logic              div_start;
        logic [1:0]        div_src;
        logic              mul_en;
        logic              add_en;
        logic              sel;
        logic              commit;
        logic              load_out;
        logic              clear_flag;
        logic              drop;
        logic [CNT_W-1:0]  m;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== sv/lfgd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lfgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/lfgd_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lfgd_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [lfgd_pkg::MAG_W-1:0]     dividend,
    input  wire logic [lfgd_pkg::DIVR_W-1:0]    divisor,
    output logic      [lfgd_pkg::MAG_W-1:0]     quotient,
    output logic                                done
);

    localparam int CW = $clog2(lfgd_pkg::MAG_W);

    logic [lfgd_pkg::MAG_W-1:0]  quo_reg, quo_next;
    logic [lfgd_pkg::DIVR_W-1:0] rem_reg, rem_next;
    logic [lfgd_pkg::DIVR_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [lfgd_pkg::DIVR_W:0]   trial;

    // One shift and trial subtraction per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[lfgd_pkg::MAG_W-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(lfgd_pkg::MAG_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = lfgd_pkg::DIVR_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[lfgd_pkg::MAG_W-2:0], 1'b1};
            end else begin
                rem_next = trial[lfgd_pkg::DIVR_W-1:0];
                quo_next = {quo_reg[lfgd_pkg::MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

// ===== sv/lfgd_datapath.sv =====
// Datapath: sample stores, error pipeline, sums, update arithmetic and result register.
`default_nettype none
module lfgd_datapath (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire lfgd_pkg::cmd_t          cmd,
    output lfgd_pkg::sts_t               sts,
    input  wire lfgd_pkg::in_item_t      s_data,
    input  wire logic [lfgd_pkg::LR_W-1:0] learn_rate,
    output lfgd_pkg::out_item_t          m_data,
    output logic                         m_valid,
    input  wire logic                    m_ready
);

    localparam int SW = lfgd_pkg::SUM_W;
    localparam int MW = lfgd_pkg::MAG_W;

    logic signed [31:0] x_rd, y_rd;

    // Sample stores
    lfgd_ram #(.WIDTH(32), .DEPTH(lfgd_pkg::MAX_SAMPLES)) u_x_store (
        .aclk(aclk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr),
        .wr_data(s_data.sample_x), .rd_addr(cmd.rd_addr), .rd_data(x_rd)
    );
    lfgd_ram #(.WIDTH(32), .DEPTH(lfgd_pkg::MAX_SAMPLES)) u_y_store (
        .aclk(aclk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr),
        .wr_data(s_data.sample_y), .rd_addr(cmd.rd_addr), .rd_data(y_rd)
    );

    logic signed [31:0] theta0_reg, theta1_reg, n0_reg, n1_reg;
    logic               v1_reg, va_reg, vb_reg, vc_reg;
    logic signed [63:0] prod1_reg, prod2_reg;
    logic signed [31:0] xa_reg, ya_reg, xb_reg, errb_reg, errc_reg;
    logic signed [SW-1:0] s0_reg, s1_reg;
    logic [MW-1:0]      cost_reg;
    logic               sat_reg, sat_next;
    logic               neg_reg;
    logic [56:0]        hi_reg;
    logic [47:0]        lo_reg;
    logic               outv_reg;
    lfgd_pkg::out_item_t out_reg;

    // Error computation with saturation
    logic signed [49:0] err_full;
    logic signed [31:0] err_sat;
    logic               err_ovf;
    always_comb begin
        err_full = 50'(theta0_reg) + 50'($signed(prod1_reg[63:16])) - 50'(ya_reg);
        err_ovf  = (err_full > 50'sd2147483647) || (err_full < -50'sd2147483648);
        if (err_full > 50'sd2147483647) begin
            err_sat = 32'sh7FFFFFFF;
        end else if (err_full < -50'sd2147483648) begin
            err_sat = 32'sh80000000;
        end else begin
            err_sat = err_full[31:0];
        end
    end

    // Magnitudes of the sums and divider operands
    logic signed [SW-1:0] s0_abs, s1_abs;
    logic [MW-1:0]        div_a;
    logic [lfgd_pkg::DIVR_W-1:0] div_b;
    logic [MW-1:0]        quo;
    logic                 div_done;
    always_comb begin
        s0_abs = s0_reg[SW-1] ? -s0_reg : s0_reg;
        s1_abs = s1_reg[SW-1] ? -s1_reg : s1_reg;
        unique case (cmd.div_src)
            lfgd_pkg::SRC_S0: div_a = s0_abs[MW-1:0];
            lfgd_pkg::SRC_S1: div_a = s1_abs[MW-1:0];
            default:          div_a = cost_reg;
        endcase
        div_b = (cmd.div_src == lfgd_pkg::SRC_COST) ? {cmd.m, 1'b0} : {1'b0, cmd.m};
    end

    lfgd_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(div_a), .divisor(div_b), .quotient(quo), .done(div_done)
    );

    // Parameter step: limit, signed subtract, saturate
    logic [57:0]        d_full;
    logic [40:0]        d_lim;
    logic signed [42:0] th_ext, th_new;
    logic signed [31:0] th_sat;
    logic               th_ovf;
    always_comb begin
        d_full = {1'b0, hi_reg} + 58'(lo_reg[47:24]);
        d_lim  = (d_full > 58'(41'h100_0000_0000)) ? 41'h100_0000_0000 : d_full[40:0];
        th_ext = cmd.sel ? 43'(theta1_reg) : 43'(theta0_reg);
        th_new = neg_reg ? th_ext + $signed({2'b00, d_lim})
                         : th_ext - $signed({2'b00, d_lim});
        th_ovf = (th_new > 43'sd2147483647) || (th_new < -43'sd2147483648);
        if (th_new > 43'sd2147483647) begin
            th_sat = 32'sh7FFFFFFF;
        end else if (th_new < -43'sd2147483648) begin
            th_sat = 32'sh80000000;
        end else begin
            th_sat = th_new[31:0];
        end
    end

    // Cost clamp
    logic        cost_ovf;
    logic [47:0] cost_out;
    always_comb begin
        cost_ovf = quo[MW-1:48] != '0;
        cost_out = cost_ovf ? 48'hFFFF_FFFF_FFFF : quo[47:0];
    end

    // Saturation flag
    always_comb begin
        sat_next = sat_reg;
        if (cmd.clear_flag) begin
            sat_next = 1'b0;
        end else if (cmd.drop || (va_reg && err_ovf) || (cmd.add_en && th_ovf)) begin
            sat_next = 1'b1;
        end
    end

    // Pipeline valid bits, flag and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            sat_reg  <= 1'b0;
            outv_reg <= 1'b0;
        end else begin
            v1_reg  <= cmd.rd_issue;
            va_reg  <= v1_reg;
            vb_reg  <= va_reg;
            vc_reg  <= vb_reg;
            sat_reg <= sat_next;
            if (cmd.load_out) begin
                outv_reg <= 1'b1;
            end else if (m_ready) begin
                outv_reg <= 1'b0;
            end
        end
    end

    // Pipeline stages, sums and parameters
    always_ff @(posedge aclk) begin
        prod1_reg <= theta1_reg * x_rd;
        xa_reg    <= x_rd;
        ya_reg    <= y_rd;
        errb_reg  <= err_sat;
        xb_reg    <= xa_reg;
        prod2_reg <= errb_reg * (cmd.cost_mode ? errb_reg : xb_reg);
        errc_reg  <= errb_reg;
        if (cmd.clear_sums) begin
            s0_reg   <= '0;
            s1_reg   <= '0;
            cost_reg <= '0;
        end else if (vc_reg) begin
            if (cmd.cost_mode) begin
                cost_reg <= cost_reg + MW'(prod2_reg[62:16]);
            end else begin
                s0_reg <= s0_reg + SW'(errc_reg);
                s1_reg <= s1_reg + SW'($signed(prod2_reg[63:16]));
            end
        end
        if (cmd.div_start) begin
            neg_reg <= (cmd.div_src == lfgd_pkg::SRC_S1) ? s1_reg[SW-1] : s0_reg[SW-1];
        end
        if (cmd.mul_en) begin
            hi_reg <= quo[56:24] * learn_rate;
            lo_reg <= quo[23:0] * learn_rate;
        end
        if (cmd.add_en) begin
            if (cmd.sel) begin
                n1_reg <= th_sat;
            end else begin
                n0_reg <= th_sat;
            end
        end
        if (cmd.clear_thetas) begin
            theta0_reg <= '0;
            theta1_reg <= '0;
        end else if (cmd.commit) begin
            theta0_reg <= n0_reg;
            theta1_reg <= n1_reg;
        end
        if (cmd.load_out) begin
            out_reg.intercept     <= theta0_reg;
            out_reg.slope         <= theta1_reg;
            out_reg.final_cost    <= cost_out;
            out_reg.samples_used  <= cmd.m;
            out_reg.overflow_flag <= sat_reg | cost_ovf;
        end
    end

    assign sts.pipe_busy = v1_reg | va_reg | vb_reg | vc_reg;
    assign sts.div_done  = div_done;
    assign sts.out_free  = !outv_reg || m_ready;
    assign m_valid       = outv_reg;
    assign m_data        = out_reg;

endmodule
`default_nettype wire

// ===== sv/lfgd_ctrl.sv =====
// Controller: loading, training passes, parameter updates and result hand-off.
`default_nettype none
module lfgd_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      last_sample,
    input  wire logic [lfgd_pkg::IT_W-1:0] iteration_count,
    input  wire lfgd_pkg::sts_t            sts,
    output lfgd_pkg::cmd_t                 cmd
);

    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_PASS   = 4'd2;
    localparam logic [3:0] ST_DRAIN  = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_WAIT   = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_ADD    = 4'd7;
    localparam logic [3:0] ST_COMMIT = 4'd8;
    localparam logic [3:0] ST_RESULT = 4'd9;

    localparam int CW = lfgd_pkg::CNT_W;
    localparam logic [CW-1:0] FULL = CW'(lfgd_pkg::MAX_SAMPLES);

    logic [3:0]                  state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [lfgd_pkg::IT_W-1:0]   iter_reg, iter_next;
    logic                        cost_reg, cost_next;
    logic                        sel_reg, sel_next;
    logic                        accept;

    assign s_ready = (state_reg == ST_LOAD);
    assign accept  = s_valid && s_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        iter_next  = iter_reg;
        cost_next  = cost_reg;
        sel_next   = sel_reg;
        cmd              = '0;
        cmd.wr_addr      = count_reg[lfgd_pkg::ADDR_W-1:0];
        cmd.rd_addr      = idx_reg[lfgd_pkg::ADDR_W-1:0];
        cmd.cost_mode    = cost_reg;
        cmd.sel          = sel_reg;
        cmd.m            = count_reg;
        cmd.div_src      = cost_reg ? lfgd_pkg::SRC_COST
                                    : (sel_reg ? lfgd_pkg::SRC_S1 : lfgd_pkg::SRC_S0);
        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (count_reg != FULL) begin
                        cmd.wr_en  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        cmd.drop = 1'b1;
                    end
                    if (last_sample) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                cmd.clear_thetas = 1'b1;
                cmd.clear_sums   = 1'b1;
                idx_next   = '0;
                iter_next  = '0;
                cost_next  = (iteration_count == '0);
                state_next = ST_PASS;
            end
            ST_PASS: begin
                cmd.rd_issue = 1'b1;
                if (idx_reg == count_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    sel_next   = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.div_done) begin
                    state_next = cost_reg ? ST_RESULT : ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add_en = 1'b1;
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit     = 1'b1;
                cmd.clear_sums = 1'b1;
                idx_next   = '0;
                iter_next  = iter_reg + 1'b1;
                cost_next  = ({1'b0, iter_reg} + 17'd1) == {1'b0, iteration_count};
                state_next = ST_PASS;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_out   = 1'b1;
                    cmd.clear_flag = 1'b1;
                    count_next = '0;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            cost_reg  <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            cost_reg  <= cost_next;
            sel_reg   <= sel_next;
        end
        idx_reg  <= idx_next;
        iter_reg <= iter_next;
    end

endmodule
`default_nettype wire

// ===== sv/linear_fit_gradient_descent.sv =====
// Top level of the linear fit trainer: configuration registers, controller and datapath.
// Samples load at one item per cycle into the x and y stores until an item marks the last;
// items beyond the store size are dropped. Each iteration then passes once through the
// store and runs the bit-serial divider for each update; a final pass sums the cost.
// The result item is held in an output register; loading resumes.
// Synchronous active-low reset clears the controller, flag and valid state and sets
// learn_rate and iteration_count to their defaults; the stores need no clearing pass.
`default_nettype none
module linear_fit_gradient_descent (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire lfgd_pkg::in_item_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output lfgd_pkg::out_item_t               m_data,
    input  wire logic                         cfg_wr_en,
    input  wire logic [lfgd_pkg::CFG_A_W-1:0] cfg_addr,
    input  wire logic [lfgd_pkg::CFG_W-1:0]   cfg_wr_data
);

    logic [lfgd_pkg::LR_W-1:0] learn_rate_reg;
    logic [lfgd_pkg::IT_W-1:0] iter_count_reg;
    lfgd_pkg::cmd_t            cmd;
    lfgd_pkg::sts_t            sts;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_rate_reg <= 24'd167772;
            iter_count_reg <= 16'd1000;
        end else if (cfg_wr_en) begin
            if (cfg_addr == lfgd_pkg::REG_LEARN_RATE) begin
                learn_rate_reg <= cfg_wr_data;
            end else if (cfg_addr == lfgd_pkg::REG_ITER_COUNT) begin
                iter_count_reg <= cfg_wr_data[lfgd_pkg::IT_W-1:0];
            end
        end
    end

    lfgd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .last_sample(s_data.last_sample), .iteration_count(iter_count_reg),
        .sts(sts), .cmd(cmd)
    );

    lfgd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .s_data(s_data),
        .learn_rate(learn_rate_reg), .m_data(m_data), .m_valid(m_valid),
        .m_ready(m_ready)
    );

endmodule
`default_nettype wire

// ===== sv/lfgd_checker.sv =====
// Port-level checks of the linear fit trainer and their binding.
`default_nettype none
module lfgd_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire lfgd_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire lfgd_pkg::out_item_t m_data
);

    // A stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // Loading stops once the last sample of a set is taken
    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_sample |=> !s_ready)
        else $error("input still ready after last sample");

    // A result is launched only from training, never from loading
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result item appeared while loading");

    // Sample count of a result lies within the store size
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.samples_used != '0) &&
                    (m_data.samples_used <= 11'(lfgd_pkg::MAX_SAMPLES)))
        else $error("sample count out of range");

endmodule

bind linear_fit_gradient_descent lfgd_checker u_lfgd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire

// ===== sim/linear_fit_checker.sv =====
// Checker for the linear fit trainer: watches all ports, predicts each fit and compares results.
module linear_fit_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  lfgd_pkg::in_item_t           s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  lfgd_pkg::out_item_t          m_data,
    input  logic                         cfg_wr_en,
    input  logic [lfgd_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [lfgd_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                         end_check,
    output int                           fits_seen,
    output int                           fail_count
);
    import lfgd_pkg::*;

    // Shadow copy of the registers and of the sample set being loaded.
    logic [LR_W-1:0]     rate;
    logic [IT_W-1:0]     passes;
    logic signed [31:0]  xs [MAX_SAMPLES];
    logic signed [31:0]  ys [MAX_SAMPLES];
    int                  loaded;
    bit                  sat_seen;
    out_item_t           fit_q [$];
    bit                  leftovers_done;

    // Clamp to signed 32 bits, noting any saturation.
    function automatic logic signed [31:0] clamp32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] residual(input logic signed [31:0] t0,
                                                    input logic signed [31:0] t1,
                                                    input int i, inout bit sat);
        longint p;
        p = (longint'(t1) * longint'(xs[i])) >>> 16;
        return clamp32(longint'(t0) + p - longint'(ys[i]), sat);
    endfunction

    // One parameter step: scaled mean gradient, limited, then subtracted.
    function automatic logic signed [31:0] descend(input logic signed [31:0] theta,
                                                   input longint sum, input int m,
                                                   inout bit sat);
        longint unsigned mag, q, d, lr;
        longint sd;
        lr  = longint'(rate);
        mag = (sum < 0) ? longint'(0) - sum : sum;
        q   = mag / longint'(m);
        d   = (q >> 24) * lr + (((q & 64'hFFFFFF) * lr) >> 24);
        if (d > (64'd1 << 40))
            d = 64'd1 << 40;
        sd = (sum < 0) ? -longint'(d) : longint'(d);
        return clamp32(longint'(theta) - sd, sat);
    endfunction

    // Full training run over the loaded set.
    function automatic out_item_t fit_line();
        out_item_t          r;
        logic signed [31:0] t0, t1, n0, n1, e;
        longint             s0, s1;
        longint unsigned    cost_sum, cost;
        bit                 sat;
        int                 m;
        m   = loaded;
        sat = sat_seen;
        t0  = '0;
        t1  = '0;
        for (int it = 0; it < int'(passes); it++) begin
            s0 = 0;
            s1 = 0;
            for (int i = 0; i < m; i++) begin
                e  = residual(t0, t1, i, sat);
                s0 += longint'(e);
                s1 += (longint'(e) * longint'(xs[i])) >>> 16;
            end
            n0 = descend(t0, s0, m, sat);
            n1 = descend(t1, s1, m, sat);
            t0 = n0;
            t1 = n1;
        end
        cost_sum = 0;
        for (int i = 0; i < m; i++) begin
            e = residual(t0, t1, i, sat);
            cost_sum += longint'(longint'(e) * longint'(e)) >> 16;
        end
        cost = cost_sum / (longint'(m) * 2);
        if (cost > 64'hFFFFFFFFFFFF) begin
            cost = 64'hFFFFFFFFFFFF;
            sat  = 1'b1;
        end
        r.intercept     = t0;
        r.slope         = t1;
        r.final_cost    = cost[47:0];
        r.samples_used  = m[10:0];
        r.overflow_flag = sat;
        return r;
    endfunction

    task automatic report(input string field, input longint unsigned want,
                          input longint unsigned got);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH %s: expected %0h, got %0h (fit %0d)", field, want, got,
                     fits_seen);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rate           <= 24'd167772;
            passes         <= 16'd1000;
            loaded         <= 0;
            sat_seen       <= 1'b0;
            fits_seen      <= 0;
            fail_count     <= 0;
            leftovers_done <= 1'b0;
        end else begin
            // Register writes; indexes outside the list are ignored.
            if (cfg_wr_en) begin
                if (cfg_addr == REG_LEARN_RATE)
                    rate <= cfg_wr_data[LR_W-1:0];
                else if (cfg_addr == REG_ITER_COUNT)
                    passes <= cfg_wr_data[IT_W-1:0];
            end

            // Accepted sample: store it or drop it when the store is full.
            if (s_valid && s_ready) begin
                if (loaded < MAX_SAMPLES) begin
                    xs[loaded] = s_data.sample_x;
                    ys[loaded] = s_data.sample_y;
                    loaded     = loaded + 1;
                end else begin
                    sat_seen = 1'b1;
                end
                if (s_data.last_sample) begin
                    fit_q.insert(fit_q.size(), fit_line());
                    loaded   = 0;
                    sat_seen = 1'b0;
                end
            end

            // Accepted result against the oldest prediction.
            if (m_valid && m_ready) begin
                if (fit_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("MISMATCH: unexpected result, intercept %0h slope %0h",
                                 m_data.intercept, m_data.slope);
                end else begin
                    out_item_t want;
                    want = fit_q.pop_front();
                    if (m_data.intercept !== want.intercept)
                        report("intercept", want.intercept, m_data.intercept);
                    if (m_data.slope !== want.slope)
                        report("slope", want.slope, m_data.slope);
                    if (m_data.final_cost !== want.final_cost)
                        report("final_cost", want.final_cost, m_data.final_cost);
                    if (m_data.samples_used !== want.samples_used)
                        report("samples_used", want.samples_used, m_data.samples_used);
                    if (m_data.overflow_flag !== want.overflow_flag)
                        report("overflow_flag", want.overflow_flag, m_data.overflow_flag);
                end
                fits_seen <= fits_seen + 1;
            end

            // Predictions never matched by a result count as failures.
            if (end_check && !leftovers_done) begin
                leftovers_done <= 1'b1;
                if (fit_q.size() != 0) begin
                    fail_count += fit_q.size();
                    $display("MISMATCH: %0d results never arrived", fit_q.size());
                end
            end
        end
    end
endmodule

// ===== sim/linear_fit_gradient_descent_tb.sv =====
// Testbench top for the linear fit trainer: clock, reset, stimulus, stalls and verdict.
module linear_fit_gradient_descent_tb;
    import lfgd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 200;
    localparam logic [CFG_A_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_SPARE_B = 2'd3;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               cfg_wr_en;
    logic [CFG_A_W-1:0] cfg_addr;
    logic [CFG_W-1:0]   cfg_wr_data;
    logic               end_check;
    int                 fits_seen;
    int                 fail_count;
    int                 sets_sent;
    int                 items_sent;
    int                 idle_cycles;
    bit                 quiet;
    bit                 hold_req;
    bit                 hold_done;

    linear_fit_gradient_descent DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    linear_fit_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .end_check   (end_check),
        .fits_seen   (fits_seen),
        .fail_count  (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random short stalls, one long hold-off on request.
    initial begin
        m_ready   <= 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly modest Q16.16 values, with extremes and full-range patterns mixed in.
    function automatic logic signed [31:0] pick_q();
        case ($urandom_range(0, 9))
            0:       return 32'sh80000000;
            1:       return 32'sh7FFFFFFF;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        endcase
    endfunction

    task automatic offer_sample(input logic signed [31:0] x, input logic signed [31:0] y,
                                input logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_data.sample_x    <= x;
        s_data.sample_y    <= y;
        s_data.last_sample <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (last)
            sets_sent++;
    endtask

    task automatic random_set(input int n);
        for (int i = 0; i < n; i++)
            offer_sample(pick_q(), pick_q(), i == n - 1);
    endtask

    // Waits for every fit, then lets the block drain before touching registers.
    task automatic settle();
        s_valid <= 1'b0;
        while (fits_seen != sets_sent) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int random_goal;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= '0;
        cfg_wr_data <= '0;
        end_check   <= 1'b0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        sets_sent   = 0;
        items_sent  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default registers on a clean line.
        offer_sample(32'sh10000, 32'sh20000, 1'b0);
        offer_sample(32'sh20000, 32'sh40000, 1'b1);
        settle();

        // Largest learning rate, one pass, extreme samples and a single-sample set.
        write_reg(REG_LEARN_RATE, 24'hFFFFFF);
        write_reg(REG_ITER_COUNT, 24'd1);
        offer_sample(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        offer_sample(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        offer_sample(32'sh0, 32'sh0, 1'b0);
        offer_sample(32'sh80000000, 32'sh80000000, 1'b0);
        offer_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);
        offer_sample(32'sh7FFFFFFF, 32'sh80000000, 1'b1);
        settle();

        // Zero learning rate; writes to unused indexes must change nothing.
        write_reg(REG_LEARN_RATE, 24'd0);
        write_reg(REG_ITER_COUNT, 24'd3);
        write_reg(REG_SPARE_A, 24'hFFFFFF);
        write_reg(REG_SPARE_B, 24'h000001);
        random_set(3);
        settle();

        // Smallest rate and zero iterations (upper data bits are not part of the count).
        write_reg(REG_LEARN_RATE, 24'd1);
        write_reg(REG_ITER_COUNT, 24'hFF0000);
        random_set(2);
        settle();

        // Long run on a single sample.
        write_reg(REG_LEARN_RATE, 24'd167772);
        write_reg(REG_ITER_COUNT, 24'd2000);
        offer_sample(32'sh18000, 32'sh30000, 1'b1);
        settle();

        // Store full: the surplus samples are dropped, the last marker still starts training.
        write_reg(REG_LEARN_RATE, 24'($urandom));
        write_reg(REG_ITER_COUNT, 24'd1);
        random_set(MAX_SAMPLES + 6);
        settle();

        // Random phases; the second one holds the result side off for a long stretch.
        random_goal = items_sent + 650;
        for (int phase = 0; items_sent < random_goal; phase++) begin
            case ($urandom_range(0, 7))
                0:       write_reg(REG_LEARN_RATE, 24'd1);
                1:       write_reg(REG_LEARN_RATE, 24'hFFFFFF);
                default: write_reg(REG_LEARN_RATE, 24'($urandom));
            endcase
            write_reg(REG_ITER_COUNT, 24'($urandom_range(1, 6)));
            if (phase == 1)
                hold_req = 1'b1;
            for (int k = $urandom_range(3, 8); k > 0; k--) begin
                if (random_goal - items_sent < 100)
                    quiet = 1'b1;
                random_set($urandom_range(1, 12));
            end
            settle();
        end

        end_check <= 1'b1;
        repeat (3) @(posedge aclk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
